// File: rtl/assert_macros.svh
// Assertion macros shared by the mesher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VFCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define VFCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/vfcm_pkg.sv
// Shared constants, types and face tables of the voxel face culling mesher.
package vfcm_pkg;

   localparam int SIZE_X    = 16;
   localparam int SIZE_Y    = 16;
   localparam int SIZE_Z    = 16;

   localparam int COORD_W   = 4;
   localparam int VERT_W    = 5;
   localparam int NORM_W    = 2;
   localparam int TEX_W     = 3;
   localparam int CNT_W     = 18;

   localparam int SIDES     = 6;
   localparam int CORNERS   = 6;
   localparam int SIDE_W    = $clog2(SIDES);
   localparam int CORNER_W  = $clog2(CORNERS);

   // One map row holds the solidity bits of all z for one (x, y).
   localparam int MAP_DEPTH = SIZE_X * SIZE_Y;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int ZIDX_W    = $clog2(SIZE_Z);

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_MESH  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   typedef struct packed {
      logic             dx;
      logic             dy;
      logic             dz;
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
   } corner_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } normal_type;

   // Side order: north, south, west, east, up, down.
   localparam normal_type SIDE_NORMAL [SIDES] = '{
      '{ 2'sd0,  2'sd0, -2'sd1},
      '{ 2'sd0,  2'sd0,  2'sd1},
      '{ 2'sd1,  2'sd0,  2'sd0},
      '{-2'sd1,  2'sd0,  2'sd0},
      '{ 2'sd0,  2'sd1,  2'sd0},
      '{ 2'sd0, -2'sd1,  2'sd0}
   };

   // Corner offsets and texcoords in quarter units, north side quirks kept.
   localparam corner_type CORNER_TABLE [SIDES][CORNERS] = '{
      '{'{1'b0,1'b0,1'b0,3'd1,3'd0}, '{1'b1,1'b1,1'b0,3'd2,3'd4},
        '{1'b1,1'b0,1'b0,3'd2,3'd0}, '{1'b0,1'b0,1'b0,3'd1,3'd2},
        '{1'b0,1'b1,1'b0,3'd1,3'd4}, '{1'b1,1'b1,1'b0,3'd0,3'd2}},
      '{'{1'b0,1'b0,1'b1,3'd1,3'd0}, '{1'b1,1'b0,1'b1,3'd2,3'd0},
        '{1'b1,1'b1,1'b1,3'd2,3'd4}, '{1'b0,1'b0,1'b1,3'd1,3'd0},
        '{1'b1,1'b1,1'b1,3'd2,3'd4}, '{1'b0,1'b1,1'b1,3'd1,3'd4}},
      '{'{1'b1,1'b0,1'b1,3'd1,3'd4}, '{1'b1,1'b0,1'b0,3'd1,3'd0},
        '{1'b1,1'b1,1'b0,3'd2,3'd0}, '{1'b1,1'b0,1'b1,3'd1,3'd4},
        '{1'b1,1'b1,1'b0,3'd2,3'd0}, '{1'b1,1'b1,1'b1,3'd2,3'd4}},
      '{'{1'b0,1'b0,1'b1,3'd1,3'd4}, '{1'b0,1'b1,1'b0,3'd2,3'd0},
        '{1'b0,1'b0,1'b0,3'd1,3'd0}, '{1'b0,1'b0,1'b1,3'd1,3'd4},
        '{1'b0,1'b1,1'b1,3'd2,3'd4}, '{1'b0,1'b1,1'b0,3'd2,3'd0}},
      '{'{1'b0,1'b1,1'b0,3'd1,3'd0}, '{1'b1,1'b1,1'b1,3'd2,3'd4},
        '{1'b1,1'b1,1'b0,3'd2,3'd0}, '{1'b0,1'b1,1'b0,3'd1,3'd0},
        '{1'b0,1'b1,1'b1,3'd1,3'd4}, '{1'b1,1'b1,1'b1,3'd2,3'd4}},
      '{'{1'b0,1'b0,1'b0,3'd1,3'd0}, '{1'b1,1'b0,1'b0,3'd2,3'd0},
        '{1'b1,1'b0,1'b1,3'd2,3'd4}, '{1'b0,1'b0,1'b0,3'd1,3'd0},
        '{1'b1,1'b0,1'b1,3'd2,3'd4}, '{1'b0,1'b0,1'b1,3'd1,3'd4}}
   };

   typedef struct packed {
      logic               start;
      logic               clear;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [SIDES-1:0]   open;
   } emit_cmd_type;

   typedef struct packed {
      logic busy;
   } emit_stat_type;

   function automatic logic [ADDR_W-1:0] map_addr(input logic [VERT_W-1:0] x,
                                                  input logic [VERT_W-1:0] y);
      return ADDR_W'(int'(x) * SIZE_Y + int'(y));
   endfunction

endpackage

// File: rtl/vfcm_map.sv
// Solidity map RAM: one row of z bits per (x, y), registered read port.
module vfcm_map (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [vfcm_pkg::ADDR_W-1:0]  rd_addr,
   output logic [vfcm_pkg::SIZE_Z-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [vfcm_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [vfcm_pkg::SIZE_Z-1:0]  wr_data
);

   logic [vfcm_pkg::SIZE_Z-1:0] mem [vfcm_pkg::MAP_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/vfcm_emit.sv
// Vertex emitter: walks open sides and corners, holds the vertex counter.
`include "assert_macros.svh"

module vfcm_emit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vfcm_pkg::emit_cmd_type                cmd,
   output vfcm_pkg::emit_stat_type               stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_x,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_y,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_z,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_x,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_y,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_z,
   output logic [vfcm_pkg::TEX_W-1:0]            rsp_tex_u,
   output logic [vfcm_pkg::TEX_W-1:0]            rsp_tex_v,
   output logic [vfcm_pkg::CNT_W-1:0]            rsp_vertex_number,
   output logic                                  rsp_last
);

   logic [vfcm_pkg::SIDES-1:0]    mask_ff, mask_in;
   logic [vfcm_pkg::CORNER_W-1:0] corner_ff, corner_in;
   logic [vfcm_pkg::COORD_W-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [vfcm_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          valid_ff, valid_in;

   logic [vfcm_pkg::VERT_W-1:0]        vert_x_ff, vert_x_in;
   logic [vfcm_pkg::VERT_W-1:0]        vert_y_ff, vert_y_in;
   logic [vfcm_pkg::VERT_W-1:0]        vert_z_ff, vert_z_in;
   logic signed [vfcm_pkg::NORM_W-1:0] normal_x_ff, normal_x_in;
   logic signed [vfcm_pkg::NORM_W-1:0] normal_y_ff, normal_y_in;
   logic signed [vfcm_pkg::NORM_W-1:0] normal_z_ff, normal_z_in;
   logic [vfcm_pkg::TEX_W-1:0]         tex_u_ff, tex_u_in, tex_v_ff, tex_v_in;
   logic [vfcm_pkg::CNT_W-1:0]         number_ff, number_in;
   logic                               last_ff, last_in;

   logic [vfcm_pkg::SIDE_W-1:0] side;
   logic [vfcm_pkg::SIDES-1:0]  rest;
   logic                        busy, load, last_corner;
   vfcm_pkg::corner_type        cn;
   vfcm_pkg::normal_type        nm;

   // lowest remaining open side is the current one
   always_comb begin
      side = '0;
      for (int s = vfcm_pkg::SIDES - 1; s >= 0; s--) begin
         if (mask_ff[s]) begin
            side = vfcm_pkg::SIDE_W'(s);
         end
      end
   end

   assign cn          = vfcm_pkg::CORNER_TABLE[side][corner_ff];
   assign nm          = vfcm_pkg::SIDE_NORMAL[side];
   assign rest        = mask_ff & (mask_ff - 1'b1);
   assign busy        = (mask_ff != '0);
   assign load        = busy && (!valid_ff || rsp_ready);
   assign last_corner = (corner_ff == vfcm_pkg::CORNER_W'(vfcm_pkg::CORNERS - 1));

   always_comb begin
      mask_in     = mask_ff;
      corner_in   = corner_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      count_in    = count_ff;
      valid_in    = valid_ff;
      vert_x_in   = vert_x_ff;
      vert_y_in   = vert_y_ff;
      vert_z_in   = vert_z_ff;
      normal_x_in = normal_x_ff;
      normal_y_in = normal_y_ff;
      normal_z_in = normal_z_ff;
      tex_u_in    = tex_u_ff;
      tex_v_in    = tex_v_ff;
      number_in   = number_ff;
      last_in     = last_ff;

      if (cmd.clear) begin
         count_in = '0;
      end

      if (cmd.start) begin
         mask_in   = cmd.open;
         corner_in = '0;
         x_in      = cmd.x;
         y_in      = cmd.y;
         z_in      = cmd.z;
      end else if (load) begin
         // advance corner; drop the side after its sixth corner
         if (last_corner) begin
            corner_in = '0;
            mask_in   = rest;
         end else begin
            corner_in = corner_ff + 1'b1;
         end
      end

      if (load) begin
         valid_in    = 1'b1;
         vert_x_in   = {1'b0, x_ff} + vfcm_pkg::VERT_W'(cn.dx);
         vert_y_in   = {1'b0, y_ff} + vfcm_pkg::VERT_W'(cn.dy);
         vert_z_in   = {1'b0, z_ff} + vfcm_pkg::VERT_W'(cn.dz);
         normal_x_in = nm.x;
         normal_y_in = nm.y;
         normal_z_in = nm.z;
         tex_u_in    = cn.u;
         tex_v_in    = cn.v;
         number_in   = count_ff;
         last_in     = last_corner && (rest == '0);
         count_in    = count_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         corner_ff <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         corner_ff <= corner_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      vert_x_ff   <= vert_x_in;
      vert_y_ff   <= vert_y_in;
      vert_z_ff   <= vert_z_in;
      normal_x_ff <= normal_x_in;
      normal_y_ff <= normal_y_in;
      normal_z_ff <= normal_z_in;
      tex_u_ff    <= tex_u_in;
      tex_v_ff    <= tex_v_in;
      number_ff   <= number_in;
      last_ff     <= last_in;
   end

   assign stat.busy         = busy;
   assign rsp_valid         = valid_ff;
   assign rsp_vert_x        = vert_x_ff;
   assign rsp_vert_y        = vert_y_ff;
   assign rsp_vert_z        = vert_z_ff;
   assign rsp_normal_x      = normal_x_ff;
   assign rsp_normal_y      = normal_y_ff;
   assign rsp_normal_z      = normal_z_ff;
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;
   assign rsp_vertex_number = number_ff;
   assign rsp_last          = last_ff;

   `VFCM_ASSERT_IMP(a_start_idle, clock, reset, cmd.start, !busy)
   `VFCM_ASSERT_IMP(a_clear_idle, clock, reset, cmd.clear, !busy && !cmd.start)
   `VFCM_ASSERT_NEXT(a_number_seq, clock, reset, load, number_ff == $past(count_ff))

endmodule

// File: rtl/voxel_face_cull_mesher.sv
// Voxel face culling mesher top level: map access sequencer and emitter.
// Write request: read row, then write row back. Clear and ignored requests leave the sequencer idle.
// Mesh request: 5 row reads on back-to-back cycles, then the verdict once the last row is back;
// vertices follow one a cycle while rsp_ready holds, up to 36 per voxel; an air or hidden voxel
// emits none. The map RAM's one read port sets the probe length; rsp stalls hold the emitter.
// After reset the map is zeroed one row a cycle, all 256 rows; req_ready stays low meanwhile.
`include "assert_macros.svh"

module voxel_face_cull_mesher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_kind,
   input  logic [vfcm_pkg::COORD_W-1:0]          req_pos_x,
   input  logic [vfcm_pkg::COORD_W-1:0]          req_pos_y,
   input  logic [vfcm_pkg::COORD_W-1:0]          req_pos_z,
   input  logic                                  req_solid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_x,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_y,
   output logic [vfcm_pkg::VERT_W-1:0]           rsp_vert_z,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_x,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_y,
   output logic signed [vfcm_pkg::NORM_W-1:0]    rsp_normal_z,
   output logic [vfcm_pkg::TEX_W-1:0]            rsp_tex_u,
   output logic [vfcm_pkg::TEX_W-1:0]            rsp_tex_v,
   output logic [vfcm_pkg::CNT_W-1:0]            rsp_vertex_number,
   output logic                                  rsp_last
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WRITE = 5'b00100,
      ST_PROBE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [vfcm_pkg::ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [vfcm_pkg::COORD_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                           solid_ff, solid_in;
   logic [2:0]                     phase_ff, phase_in;
   logic                           center_ff, center_in;
   logic [vfcm_pkg::SIDES-1:0]     nb_ff, nb_in;

   // map RAM ports
   logic                           rd_en, wr_en;
   logic [vfcm_pkg::ADDR_W-1:0]    rd_addr, wr_addr;
   logic [vfcm_pkg::SIZE_Z-1:0]    rd_data, wr_data;

   vfcm_pkg::emit_cmd_type         cmd;
   vfcm_pkg::emit_stat_type        stat;

   logic                           in_range;
   logic [vfcm_pkg::VERT_W-1:0]    xe, ye, req_xe, req_ye;
   logic [vfcm_pkg::ZIDX_W-1:0]    zi, zi_dn, zi_up;
   logic                           row_bit;
   logic [vfcm_pkg::SIDES-1:0]     nb_all;
   logic [3:0]                     solids, border;
   logic                           exposed;

   assign req_ready = (state_ff == ST_IDLE);

   assign in_range = (int'(req_pos_x) < vfcm_pkg::SIZE_X) &&
                     (int'(req_pos_y) < vfcm_pkg::SIZE_Y) &&
                     (int'(req_pos_z) < vfcm_pkg::SIZE_Z);

   assign xe      = {1'b0, x_ff};
   assign ye      = {1'b0, y_ff};
   assign req_xe  = {1'b0, req_pos_x};
   assign req_ye  = {1'b0, req_pos_y};
   assign zi      = vfcm_pkg::ZIDX_W'(z_ff);
   assign zi_dn   = zi - 1'b1;
   assign zi_up   = zi + 1'b1;
   assign row_bit = rd_data[zi];

   // the down neighbor arrives in the last probe phase; others are held
   assign nb_all  = {(y_ff != '0) && row_bit, nb_ff[vfcm_pkg::SIDES-2:0]};
   assign solids  = 4'($countones(nb_all));
   assign border  = {3'b0, x_ff == '0}
                  + {3'b0, int'(x_ff) == vfcm_pkg::SIZE_X - 1}
                  + {3'b0, y_ff == '0}
                  + {3'b0, int'(y_ff) == vfcm_pkg::SIZE_Y - 1}
                  + {3'b0, z_ff == '0}
                  + {3'b0, int'(z_ff) == vfcm_pkg::SIZE_Z - 1};
   // enclosed: every side is a solid neighbor or the chunk border
   assign exposed = center_ff && ((solids + border) != 4'd6);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      solid_in    = solid_ff;
      phase_in    = phase_ff;
      center_in   = center_ff;
      nb_in       = nb_ff;
      rd_en       = 1'b0;
      rd_addr     = vfcm_pkg::map_addr(xe, ye);
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = '0;
      cmd         = '0;
      cmd.x       = x_ff;
      cmd.y       = y_ff;
      cmd.z       = z_ff;
      cmd.open    = ~nb_all;

      case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == vfcm_pkg::ADDR_W'(vfcm_pkg::MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            x_in     = req_pos_x;
            y_in     = req_pos_y;
            z_in     = req_pos_z;
            solid_in = req_solid;
            phase_in = '0;
            rd_addr  = vfcm_pkg::map_addr(req_xe, req_ye);
            if (req_valid) begin
               case (req_kind)
                  vfcm_pkg::KIND_WRITE: begin
                     if (in_range) begin
                        rd_en    = 1'b1;
                        state_in = ST_WRITE;
                     end
                  end
                  vfcm_pkg::KIND_MESH: begin
                     if (in_range) begin
                        rd_en    = 1'b1;
                        state_in = ST_PROBE;
                     end
                  end
                  vfcm_pkg::KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE: begin
            // merge the new bit into the row just read
            wr_en       = 1'b1;
            wr_addr     = vfcm_pkg::map_addr(xe, ye);
            wr_data     = rd_data;
            wr_data[zi] = solid_ff;
            state_in    = ST_IDLE;
         end
         ST_PROBE: begin
            phase_in = phase_ff + 1'b1;
            case (phase_ff)
               3'd0: begin
                  // own row: center plus north and south neighbors
                  center_in = row_bit;
                  nb_in[0]  = (z_ff != '0) && rd_data[zi_dn];
                  nb_in[1]  = (int'(z_ff) < vfcm_pkg::SIZE_Z - 1) && rd_data[zi_up];
                  rd_en     = 1'b1;
                  rd_addr   = vfcm_pkg::map_addr(xe + 1'b1, ye);
               end
               3'd1: begin
                  nb_in[2] = (int'(x_ff) < vfcm_pkg::SIZE_X - 1) && row_bit;
                  rd_en    = 1'b1;
                  rd_addr  = vfcm_pkg::map_addr(xe - 1'b1, ye);
               end
               3'd2: begin
                  nb_in[3] = (x_ff != '0) && row_bit;
                  rd_en    = 1'b1;
                  rd_addr  = vfcm_pkg::map_addr(xe, ye + 1'b1);
               end
               3'd3: begin
                  nb_in[4] = (int'(y_ff) < vfcm_pkg::SIZE_Y - 1) && row_bit;
                  rd_en    = 1'b1;
                  rd_addr  = vfcm_pkg::map_addr(xe, ye - 1'b1);
               end
               default: begin
                  // down neighbor in hand: decide and hand off
                  if (exposed) begin
                     cmd.start = 1'b1;
                     state_in  = ST_EMIT;
                  end else begin
                     state_in  = ST_IDLE;
                  end
               end
            endcase
         end
         ST_EMIT: begin
            // hold until the emitter has queued its last vertex
            if (!stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         phase_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         phase_ff    <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      solid_ff  <= solid_in;
      center_ff <= center_in;
      nb_ff     <= nb_in;
   end

   vfcm_map u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   vfcm_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vert_x        (rsp_vert_x),
      .rsp_vert_y        (rsp_vert_y),
      .rsp_vert_z        (rsp_vert_z),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last          (rsp_last)
   );

   `VFCM_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !stat.busy)
   `VFCM_ASSERT_NEXT(a_write_once, clock, reset, state_ff == ST_WRITE, state_ff == ST_IDLE)
   `VFCM_ASSERT_IMP(a_probe_bound, clock, reset, state_ff == ST_PROBE, phase_ff <= 3'd4)

endmodule

// File: sim/vfcm_mesh_checker.sv
// Mesh checker: tracks the voxel map and vertex counter, predicts vertices, compares them.
module vfcm_mesh_checker (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   input  logic                                         req_ready,
   input  logic [1:0]                                   req_kind,
   input  logic [vfcm_pkg::COORD_W-1:0]                 req_pos_x,
   input  logic [vfcm_pkg::COORD_W-1:0]                 req_pos_y,
   input  logic [vfcm_pkg::COORD_W-1:0]                 req_pos_z,
   input  logic                                         req_solid,
   input  logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   input  logic [vfcm_pkg::VERT_W-1:0]                  rsp_vert_x,
   input  logic [vfcm_pkg::VERT_W-1:0]                  rsp_vert_y,
   input  logic [vfcm_pkg::VERT_W-1:0]                  rsp_vert_z,
   input  logic signed [vfcm_pkg::NORM_W-1:0]           rsp_normal_x,
   input  logic signed [vfcm_pkg::NORM_W-1:0]           rsp_normal_y,
   input  logic signed [vfcm_pkg::NORM_W-1:0]           rsp_normal_z,
   input  logic [vfcm_pkg::TEX_W-1:0]                   rsp_tex_u,
   input  logic [vfcm_pkg::TEX_W-1:0]                   rsp_tex_v,
   input  logic [vfcm_pkg::CNT_W-1:0]                   rsp_vertex_number,
   input  logic                                         rsp_last,
   output int                                           pending,
   output int                                           failures
);

   localparam int NUM_SIDES   = 6;
   localparam int NUM_CORNERS = 6;
   localparam int MAX_REPORTS = 10;
   localparam int VOXELS      = vfcm_pkg::SIZE_X * vfcm_pkg::SIZE_Y * vfcm_pkg::SIZE_Z;

   typedef enum int {NORTH, SOUTH, WEST, EAST, UP, DOWN} side_type;

   typedef struct packed {
      logic [vfcm_pkg::VERT_W-1:0]        vx;
      logic [vfcm_pkg::VERT_W-1:0]        vy;
      logic [vfcm_pkg::VERT_W-1:0]        vz;
      logic signed [vfcm_pkg::NORM_W-1:0] nx;
      logic signed [vfcm_pkg::NORM_W-1:0] ny;
      logic signed [vfcm_pkg::NORM_W-1:0] nz;
      logic [vfcm_pkg::TEX_W-1:0]         tu;
      logic [vfcm_pkg::TEX_W-1:0]         tv;
      logic [vfcm_pkg::CNT_W-1:0]         num;
      logic                               last;
   } vertex_type;

   vertex_type                 vertex_queue[$];
   bit                         solid_map[VOXELS];
   logic [vfcm_pkg::CNT_W-1:0] vertex_count;
   int                         reported;

   // Corner nibbles: dx, dy, dz, u, v (texcoords in quarter units).
   function automatic logic [19:0] corner_code(input int s, input int c);
      logic [119:0] row;
      case (s)
         NORTH:   row = {20'h00010, 20'h11024, 20'h10020, 20'h00012, 20'h01014, 20'h11002};
         SOUTH:   row = {20'h00110, 20'h10120, 20'h11124, 20'h00110, 20'h11124, 20'h01114};
         WEST:    row = {20'h10114, 20'h10010, 20'h11020, 20'h10114, 20'h11020, 20'h11124};
         EAST:    row = {20'h00114, 20'h01020, 20'h00010, 20'h00114, 20'h01124, 20'h01020};
         UP:      row = {20'h01010, 20'h11124, 20'h11020, 20'h01010, 20'h01114, 20'h11124};
         default: row = {20'h00010, 20'h10020, 20'h10124, 20'h00010, 20'h10124, 20'h00114};
      endcase
      return row[(NUM_CORNERS-1-c)*20 +: 20];
   endfunction

   // Normal as {x, y, z}, two bits each, two's complement.
   function automatic logic [5:0] side_normal(input int s);
      case (s)
         NORTH:   return 6'b00_00_11;
         SOUTH:   return 6'b00_00_01;
         WEST:    return 6'b01_00_00;
         EAST:    return 6'b11_00_00;
         UP:      return 6'b00_01_00;
         default: return 6'b00_11_00;
      endcase
   endfunction

   function automatic bit solid_at(input int x, input int y, input int z);
      if (x < 0 || x >= vfcm_pkg::SIZE_X || y < 0 || y >= vfcm_pkg::SIZE_Y ||
          z < 0 || z >= vfcm_pkg::SIZE_Z)
         return 1'b0;
      return solid_map[(x*vfcm_pkg::SIZE_Y + y)*vfcm_pkg::SIZE_Z + z];
   endfunction

   function automatic string describe(input vertex_type v);
      return $sformatf("#%0d pos %0d,%0d,%0d nrm %0d,%0d,%0d uv %0d,%0d last %0b",
                       v.num, v.vx, v.vy, v.vz, v.nx, v.ny, v.nz, v.tu, v.tv, v.last);
   endfunction

   task automatic mesh_voxel(input int x, input int y, input int z);
      bit               open[NUM_SIDES];
      int               covered;
      int               border;
      int               total;
      int               n;
      logic [19:0]      k;
      logic [5:0]       nrm;
      vertex_type       v;
      if (!solid_at(x, y, z))
         return;
      open[NORTH] = !solid_at(x, y, z-1);
      open[SOUTH] = !solid_at(x, y, z+1);
      open[WEST]  = !solid_at(x+1, y, z);
      open[EAST]  = !solid_at(x-1, y, z);
      open[UP]    = !solid_at(x, y+1, z);
      open[DOWN]  = !solid_at(x, y-1, z);
      covered = 0;
      for (int s = 0; s < NUM_SIDES; s++)
         if (!open[s])
            covered++;
      border = int'(x == 0) + int'(x == vfcm_pkg::SIZE_X-1)
             + int'(y == 0) + int'(y == vfcm_pkg::SIZE_Y-1)
             + int'(z == 0) + int'(z == vfcm_pkg::SIZE_Z-1);
      // Enclosed: solid neighbours plus border sides hide the voxel completely.
      if (covered + border == NUM_SIDES)
         return;
      total = (NUM_SIDES - covered) * NUM_CORNERS;
      n = 0;
      for (int s = 0; s < NUM_SIDES; s++) begin
         if (!open[s])
            continue;
         nrm = side_normal(s);
         for (int c = 0; c < NUM_CORNERS; c++) begin
            k = corner_code(s, c);
            v.vx   = vfcm_pkg::VERT_W'(x + int'(k[16]));
            v.vy   = vfcm_pkg::VERT_W'(y + int'(k[12]));
            v.vz   = vfcm_pkg::VERT_W'(z + int'(k[8]));
            v.nx   = nrm[5:4];
            v.ny   = nrm[3:2];
            v.nz   = nrm[1:0];
            v.tu   = k[6:4];
            v.tv   = k[2:0];
            v.num  = vertex_count;
            v.last = (n == total - 1);
            vertex_queue = {vertex_queue, v};
            vertex_count = vertex_count + 1'b1;
            n++;
         end
      end
   endtask

   always @(posedge clock) begin
      vertex_type got;
      vertex_type want;
      if (reset) begin
         foreach (solid_map[i])
            solid_map[i] = 1'b0;
         vertex_count = '0;
         vertex_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_vert_x, rsp_vert_y, rsp_vert_z, rsp_normal_x, rsp_normal_y,
                    rsp_normal_z, rsp_tex_u, rsp_tex_v, rsp_vertex_number, rsp_last};
            if (vertex_queue.size() == 0) begin
               failures++;
               if (reported < MAX_REPORTS) begin
                  reported++;
                  $display("checker: unexpected vertex, expected none, got %s",
                           describe(got));
               end
            end else begin
               want = vertex_queue.pop_front();
               if (got !== want) begin
                  failures++;
                  if (reported < MAX_REPORTS) begin
                     reported++;
                     $display("checker: vertex mismatch, expected %s, got %s",
                              describe(want), describe(got));
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_kind)
               vfcm_pkg::KIND_WRITE:
                  if (int'(req_pos_x) < vfcm_pkg::SIZE_X && int'(req_pos_y) < vfcm_pkg::SIZE_Y
                      && int'(req_pos_z) < vfcm_pkg::SIZE_Z)
                     solid_map[(int'(req_pos_x)*vfcm_pkg::SIZE_Y + int'(req_pos_y))
                               *vfcm_pkg::SIZE_Z + int'(req_pos_z)] = req_solid;
               vfcm_pkg::KIND_MESH:
                  mesh_voxel(int'(req_pos_x), int'(req_pos_y), int'(req_pos_z));
               vfcm_pkg::KIND_CLEAR:
                  vertex_count = '0;
               default: ;
            endcase
         end
      end
      pending = vertex_queue.size();
   end

endmodule

// File: sim/tb.sv
// Testbench top: drives requests and backpressure on the mesher and reports the verdict.
module tb;

   // Kind code the block must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off under pressure
   localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for outstanding vertices
   localparam int SETTLE       = 60;     // mesh latency plus margin at the end
   localparam int IDLE_PERCENT = 30;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [1:0]                          req_kind;
   logic [vfcm_pkg::COORD_W-1:0]        req_pos_x;
   logic [vfcm_pkg::COORD_W-1:0]        req_pos_y;
   logic [vfcm_pkg::COORD_W-1:0]        req_pos_z;
   logic                                req_solid;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_x;
   logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_y;
   logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_z;
   logic signed [vfcm_pkg::NORM_W-1:0]  rsp_normal_x;
   logic signed [vfcm_pkg::NORM_W-1:0]  rsp_normal_y;
   logic signed [vfcm_pkg::NORM_W-1:0]  rsp_normal_z;
   logic [vfcm_pkg::TEX_W-1:0]          rsp_tex_u;
   logic [vfcm_pkg::TEX_W-1:0]          rsp_tex_v;
   logic [vfcm_pkg::CNT_W-1:0]          rsp_vertex_number;
   logic                                rsp_last;

   int   vertices_due;
   int   failures;

   // Written only by the request process, read by the receiver.
   bit   calm;            // no idling on either side while set
   int   hold_request;    // bump to make the receiver hold off
   bit   stuck;           // outstanding vertices never arrived

   // Region that focused random traffic works in, so neighbours collide often.
   int   base_x;
   int   base_y;
   int   base_z;

   voxel_face_cull_mesher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_solid         (req_solid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vert_x        (rsp_vert_x),
      .rsp_vert_y        (rsp_vert_y),
      .rsp_vert_z        (rsp_vert_z),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last          (rsp_last)
   );

   vfcm_mesh_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_solid         (req_solid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vert_x        (rsp_vert_x),
      .rsp_vert_y        (rsp_vert_y),
      .rsp_vert_z        (rsp_vert_z),
      .rsp_normal_x      (rsp_normal_x),
      .rsp_normal_y      (rsp_normal_y),
      .rsp_normal_z      (rsp_normal_z),
      .rsp_tex_u         (rsp_tex_u),
      .rsp_tex_v         (rsp_tex_v),
      .rsp_vertex_number (rsp_vertex_number),
      .rsp_last          (rsp_last),
      .pending           (vertices_due),
      .failures          (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: far beyond the slowest legal run, clearing pass included.
   initial begin
      #5000000;
      $display("tb: done, errors");
      $finish;
   end

   // Receiver: drive rsp_ready at the falling edge. Honor a hold-off request first,
   // stay ready during calm stretches, otherwise stall about 30 percent of the time.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offer one request. Start and end at a falling edge; idle first unless calm,
   // then hold valid and payload until the request is taken.
   task automatic offer(input logic [1:0] kind, input int x, input int y, input int z,
                        input logic solid);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_pos_x <= vfcm_pkg::COORD_W'(x);
      req_pos_y <= vfcm_pkg::COORD_W'(y);
      req_pos_z <= vfcm_pkg::COORD_W'(z);
      req_solid <= solid;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Pause the sender until every predicted vertex has come back or DRAIN_LIMIT runs out.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (vertices_due != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (vertices_due != 0)
         stuck = 1'b1;
      @(negedge clock);
   endtask

   // Pick a 3x3x3 work region; lean toward the chunk borders.
   task automatic pick_region();
      int r;
      r = $urandom_range(2);
      base_x = (r == 0) ? 0 : (r == 1) ? vfcm_pkg::SIZE_X-3 : $urandom_range(vfcm_pkg::SIZE_X-3);
      r = $urandom_range(2);
      base_y = (r == 0) ? 0 : (r == 1) ? vfcm_pkg::SIZE_Y-3 : $urandom_range(vfcm_pkg::SIZE_Y-3);
      r = $urandom_range(2);
      base_z = (r == 0) ? 0 : (r == 1) ? vfcm_pkg::SIZE_Z-3 : $urandom_range(vfcm_pkg::SIZE_Z-3);
   endtask

   // One random request: mostly writes and meshes near the region, mostly solid,
   // so clusters form and hide faces; a few clears and ignored kinds as noise.
   task automatic random_request();
      int          r;
      logic [1:0]  kind;
      int          x;
      int          y;
      int          z;
      r = $urandom_range(99);
      if (r < 3)
         kind = vfcm_pkg::KIND_CLEAR;
      else if (r < 5)
         kind = KIND_UNUSED;
      else if (r < 58)
         kind = vfcm_pkg::KIND_WRITE;
      else
         kind = vfcm_pkg::KIND_MESH;
      if ($urandom_range(9) < 8) begin
         x = base_x + $urandom_range(2);
         y = base_y + $urandom_range(2);
         z = base_z + $urandom_range(2);
      end else begin
         x = $urandom_range(vfcm_pkg::SIZE_X-1);
         y = $urandom_range(vfcm_pkg::SIZE_Y-1);
         z = $urandom_range(vfcm_pkg::SIZE_Z-1);
      end
      offer(kind, x, y, z, $urandom_range(3) != 0);
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0)
            pick_region();
         random_request();
      end
   endtask

   initial begin
      calm         = 1'b0;
      hold_request = 0;
      stuck        = 1'b0;
      base_x       = 0;
      base_y       = 0;
      base_z       = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_kind     = vfcm_pkg::KIND_WRITE;
      req_pos_x    = '0;
      req_pos_y    = '0;
      req_pos_z    = '0;
      req_solid    = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: air voxel, lone corner voxels, enclosure by border, clear, noise kind.
      offer(vfcm_pkg::KIND_MESH,  0, 0, 0, 1'b0);       // air: nothing
      offer(vfcm_pkg::KIND_WRITE, 0, 0, 0, 1'b1);
      offer(vfcm_pkg::KIND_MESH,  0, 0, 0, 1'b0);       // all six sides
      offer(vfcm_pkg::KIND_WRITE, 15, 15, 15, 1'b1);
      offer(vfcm_pkg::KIND_MESH,  15, 15, 15, 1'b0);    // all six sides at the far corner
      offer(vfcm_pkg::KIND_WRITE, 14, 15, 15, 1'b1);
      offer(vfcm_pkg::KIND_WRITE, 15, 14, 15, 1'b1);
      offer(vfcm_pkg::KIND_WRITE, 15, 15, 14, 1'b1);
      offer(vfcm_pkg::KIND_MESH,  15, 15, 15, 1'b1);    // enclosed: border sides stay hidden
      offer(vfcm_pkg::KIND_MESH,  14, 15, 15, 1'b1);    // partly covered, border sides exposed
      offer(vfcm_pkg::KIND_CLEAR, 15, 15, 15, 1'b1);
      offer(vfcm_pkg::KIND_MESH,  14, 15, 15, 1'b0);    // numbering restarts at zero
      offer(KIND_UNUSED, 15, 15, 15, 1'b0);             // ignored, must not touch the map
      offer(vfcm_pkg::KIND_MESH,  15, 15, 15, 1'b0);
      offer(vfcm_pkg::KIND_WRITE, 15, 15, 15, 1'b0);    // erase
      offer(vfcm_pkg::KIND_MESH,  15, 15, 15, 1'b0);    // air again
      offer(vfcm_pkg::KIND_MESH,  14, 15, 15, 1'b0);    // west side reopened
      offer(vfcm_pkg::KIND_WRITE, 10, 5, 3, 1'b1);
      offer(vfcm_pkg::KIND_MESH,  10, 5, 3, 1'b0);
      offer(vfcm_pkg::KIND_CLEAR, 5, 10, 12, 1'b0);
      offer(vfcm_pkg::KIND_MESH,  15, 14, 15, 1'b0);

      random_phase(150);

      // Pressure: fill a 2x2x2 block, then keep meshing it back to back while the
      // receiver holds off, so the block backs up and stalls its input.
      drain();
      pick_region();
      calm = 1'b1;
      for (int i = 0; i < 8; i++)
         offer(vfcm_pkg::KIND_WRITE, base_x + i[0], base_y + i[1], base_z + i[2], 1'b1);
      hold_request++;
      for (int i = 0; i < 30; i++)
         offer(vfcm_pkg::KIND_MESH, base_x + $urandom_range(1), base_y + $urandom_range(1),
               base_z + $urandom_range(1), 1'b0);
      drain();

      // Stretch with no idling on either side.
      random_phase(80);
      calm = 1'b0;

      random_phase(130);

      drain();
      repeat (SETTLE) @(negedge clock);
      if (!stuck && failures == 0 && vertices_due == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vfcm_pkg.sv
rtl/vfcm_map.sv
rtl/vfcm_emit.sv
rtl/voxel_face_cull_mesher.sv
sim/vfcm_mesh_checker.sv
sim/tb.sv
